/* rtl/iss_pkg.sv */
`default_nettype none

package iss_pkg;

    // field widths of the item channels
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int DATA_W = 8;
    localparam int LEN_W  = 5;

    // default number of byte cells in the row
    localparam int CAPACITY_DEFAULT = 16;

    // operation codes carried by an input item
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_READ       = 3'd6,
        OP_WRITE      = 3'd7
    } op_t;

    // edit broadcast along the row of cells
    typedef enum logic [1:0] {
        EDIT_HOLD   = 2'd0,
        EDIT_INSERT = 2'd1,
        EDIT_ERASE  = 2'd2,
        EDIT_WRITE  = 2'd3
    } edit_t;

    typedef struct packed {
        edit_t             kind;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/iss_req_if.sv */
`default_nettype none

interface iss_req_if;
    logic                       valid;
    logic                       ready;
    logic [iss_pkg::OP_W-1:0]   op;
    logic [iss_pkg::POS_W-1:0]  position;
    logic [iss_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

`default_nettype wire

/* rtl/iss_rsp_if.sv */
`default_nettype none

interface iss_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [iss_pkg::DATA_W-1:0] read_value;
    logic [iss_pkg::LEN_W-1:0]  length;

    modport source (output valid, output ok, output read_value, output length, input ready);
    modport sink   (input valid, input ok, input read_value, input length, output ready);
endinterface

`default_nettype wire

/* rtl/iss_cell.sv */
`default_nettype none

module iss_cell #(
    parameter int W     = 5,
    parameter int INDEX = 0
) (
    input  wire logic                       clk,
    input  wire iss_pkg::cell_cmd_t         cmd,
    input  wire logic [W-1:0]               pos,
    input  wire logic [W-1:0]               count,
    input  wire logic [iss_pkg::DATA_W-1:0] left_data,
    input  wire logic [iss_pkg::DATA_W-1:0] right_data,
    output      logic [iss_pkg::DATA_W-1:0] data
);

    localparam logic [W-1:0] IDX    = W'(INDEX);
    localparam logic [W-1:0] IDX_P1 = W'(INDEX + 1);

    logic [iss_pkg::DATA_W-1:0] data_reg;
    logic [iss_pkg::DATA_W-1:0] data_next;

    // pick load, shift from left, shift from right or hold
    always_comb
    begin
        data_next = data_reg;
        case (cmd.kind)
            iss_pkg::EDIT_INSERT:
            begin
                if (IDX == pos)
                    data_next = cmd.value;
                else if (IDX > pos && IDX <= count)
                    data_next = left_data;
            end
            iss_pkg::EDIT_ERASE:
            begin
                if (IDX >= pos && IDX_P1 < count)
                    data_next = right_data;
            end
            iss_pkg::EDIT_WRITE:
            begin
                if (IDX == pos)
                    data_next = cmd.value;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // byte storage, undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* rtl/iss_ctrl.sv */
`default_nettype none

module iss_ctrl #(
    parameter int CAPACITY = iss_pkg::CAPACITY_DEFAULT,
    parameter int CW       = 5,
    parameter int W        = 5
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [iss_pkg::OP_W-1:0]   op,
    input  wire logic [iss_pkg::POS_W-1:0]  position,
    input  wire logic [iss_pkg::DATA_W-1:0] value,
    output      iss_pkg::cell_cmd_t         cmd,
    output      logic [W-1:0]               pos_eff,
    output      logic [W-1:0]               count,
    output      logic [W-1:0]               count_next,
    output      logic                       ok,
    output      logic                       is_read
);

    localparam logic [W-1:0] CAP_W = W'(CAPACITY);

    logic [CW-1:0]       count_reg;
    logic [W-1:0]        cnt;
    logic [W-1:0]        pos_w;
    iss_pkg::edit_t      kind_sel;

    assign cnt   = W'(count_reg);
    assign pos_w = W'(position);
    assign count = cnt;

    // decode the operation into an edit, its position and its check
    always_comb
    begin
        pos_eff  = pos_w;
        kind_sel = iss_pkg::EDIT_HOLD;
        ok       = 1'b0;
        is_read  = 1'b0;
        case (iss_pkg::op_t'(op))
            iss_pkg::OP_PUSH_FRONT:
            begin
                pos_eff  = '0;
                kind_sel = iss_pkg::EDIT_INSERT;
                ok       = (cnt < CAP_W);
            end
            iss_pkg::OP_PUSH_BACK:
            begin
                pos_eff  = cnt;
                kind_sel = iss_pkg::EDIT_INSERT;
                ok       = (cnt < CAP_W);
            end
            iss_pkg::OP_POP_FRONT:
            begin
                pos_eff  = '0;
                kind_sel = iss_pkg::EDIT_ERASE;
                ok       = (cnt != '0);
            end
            iss_pkg::OP_POP_BACK:
            begin
                pos_eff  = cnt - W'(1);
                kind_sel = iss_pkg::EDIT_ERASE;
                ok       = (cnt != '0);
            end
            iss_pkg::OP_INSERT:
            begin
                kind_sel = iss_pkg::EDIT_INSERT;
                ok       = (cnt < CAP_W) && (pos_w <= cnt);
            end
            iss_pkg::OP_ERASE:
            begin
                kind_sel = iss_pkg::EDIT_ERASE;
                ok       = (pos_w < cnt);
            end
            iss_pkg::OP_READ:
            begin
                is_read  = 1'b1;
                ok       = (pos_w < cnt);
            end
            iss_pkg::OP_WRITE:
            begin
                kind_sel = iss_pkg::EDIT_WRITE;
                ok       = (pos_w < cnt);
            end
            default:
            begin
                ok       = 1'b0;
            end
        endcase
    end

    // broadcast only for an accepted item that passed its check
    always_comb
    begin
        cmd.kind  = (accept && ok) ? kind_sel : iss_pkg::EDIT_HOLD;
        cmd.value = value;
    end

    // length after the operation
    always_comb
    begin
        count_next = cnt;
        if (ok && kind_sel == iss_pkg::EDIT_INSERT)
            count_next = cnt + W'(1);
        else if (ok && kind_sel == iss_pkg::EDIT_ERASE)
            count_next = cnt - W'(1);
    end

    // element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next[CW-1:0];
    end

endmodule

`default_nettype wire

/* rtl/indexed_sequence_store.sv */
// an accepted item's result is registered and shown on rsp in the next cycle
// throughput: one item per cycle while rsp takes each result; every cell shifts, loads or holds in parallel
// an item is taken while a finished result waits, as long as rsp takes it too
// reset clears the element count and the result valid flag; the result payload
// and cell bytes keep whatever they hold and are never read before written
`default_nettype none

module indexed_sequence_store #(
    parameter int CAPACITY = iss_pkg::CAPACITY_DEFAULT
) (
    input wire logic   clk,
    input wire logic   rst_n,
    iss_req_if.sink    req,
    iss_rsp_if.source  rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int W  = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;
    localparam int PW = iss_pkg::POS_W;
    localparam int RD = (CAPACITY < (1 << PW)) ? CAPACITY : (1 << PW);

    logic                       accept;
    iss_pkg::cell_cmd_t         cmd;
    logic [W-1:0]               pos_eff;
    logic [W-1:0]               count;
    logic [W-1:0]               count_next;
    logic                       ok;
    logic                       is_read;
    logic [iss_pkg::DATA_W-1:0] cell_data [CAPACITY];
    logic [iss_pkg::DATA_W-1:0] rd_data;

    logic                       out_valid_reg;
    logic                       ok_reg;
    logic [iss_pkg::DATA_W-1:0] read_value_reg;
    logic [iss_pkg::LEN_W-1:0]  length_reg;

    // take an item whenever the result register is free or being emptied
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    iss_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .W        (W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (req.op),
        .position   (req.position),
        .value      (req.value),
        .cmd        (cmd),
        .pos_eff    (pos_eff),
        .count      (count),
        .count_next (count_next),
        .ok         (ok),
        .is_read    (is_read)
    );

    // row of byte cells, each wired to its neighbours; the end cells see zero past the row
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [iss_pkg::DATA_W-1:0] left_data;
        logic [iss_pkg::DATA_W-1:0] right_data;

        if (g == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_inner_l
            assign left_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_inner_r
            assign right_data = cell_data[g+1];
        end

        iss_cell #(
            .W     (W),
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos_eff),
            .count      (count),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[g])
        );
    end

    // read select over the cells a position can reach
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < RD; i++)
        begin
            if (req.position == PW'(i))
                rd_data = rd_data | cell_data[i];
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg         <= ok;
            read_value_reg <= (is_read && ok) ? rd_data : '0;
            length_reg     <= count_next[iss_pkg::LEN_W-1:0];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.length     = length_reg;

endmodule

`default_nettype wire

/* sim/sequence_store_checker.sv */
`timescale 1ns / 100ps
`default_nettype none

module sequence_store_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    iss_req_if        req,
    iss_rsp_if        rsp,
    output int        fail_count,
    output int        awaited,
    output int        fill_level,
    output int        results_seen,
    output int        refusals
);

    localparam int CAP = iss_pkg::CAPACITY_DEFAULT;
    localparam int DW  = iss_pkg::DATA_W;
    localparam int LW  = iss_pkg::LEN_W;

    typedef struct packed {
        logic          ok;
        logic [DW-1:0] read_value;
        logic [LW-1:0] length;
    } outcome_t;

    // mirror of the stored sequence
    logic [DW-1:0] row [CAP];
    int            held;

    outcome_t expected_outcomes [$];

    // open a gap at where and drop the byte into it
    function automatic bit insert_at(input int where, input logic [DW-1:0] val);
        if (held >= CAP || where > held)
            return 1'b0;
        for (int i = held; i > where; i--)
            row[i] = row[i-1];
        row[where] = val;
        held++;
        return 1'b1;
    endfunction

    // close the gap left by the byte at where
    function automatic bit remove_at(input int where);
        if (where >= held)
            return 1'b0;
        for (int i = where; i + 1 < held; i++)
            row[i] = row[i+1];
        held--;
        return 1'b1;
    endfunction

    // apply one operation to the mirror and return what the block should answer
    function automatic outcome_t apply_edit(input iss_pkg::op_t code, input int where,
                                            input logic [DW-1:0] val);
        outcome_t res;
        res = '0;
        case (code)
            iss_pkg::OP_PUSH_FRONT: res.ok = insert_at(0, val);
            iss_pkg::OP_PUSH_BACK:  res.ok = insert_at(held, val);
            iss_pkg::OP_POP_FRONT:  res.ok = remove_at(0);
            iss_pkg::OP_POP_BACK:
            begin
                if (held > 0)
                    res.ok = remove_at(held - 1);
            end
            iss_pkg::OP_INSERT:     res.ok = insert_at(where, val);
            iss_pkg::OP_ERASE:      res.ok = remove_at(where);
            iss_pkg::OP_READ:
            begin
                if (where < held)
                begin
                    res.read_value = row[where];
                    res.ok         = 1'b1;
                end
            end
            default:
            begin
                if (where < held)
                begin
                    row[where] = val;
                    res.ok     = 1'b1;
                end
            end
        endcase
        res.length = LW'(held);
        return res;
    endfunction

    // results are checked before the item of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        outcome_t fresh;
        if (!rst_n)
        begin
            expected_outcomes.delete();
            held         = 0;
            fail_count   = 0;
            awaited      = 0;
            fill_level   = 0;
            results_seen = 0;
            refusals     = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.ok, rsp.read_value, rsp.length};
                results_seen++;
                if (!got.ok)
                    refusals++;
                if (expected_outcomes.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing awaited: ok=%0b read=%02h len=%0d",
                                 $realtime, got.ok, got.read_value, got.length);
                    fail_count++;
                end
                else
                begin
                    want = expected_outcomes[0];
                    expected_outcomes.delete(0);
                    if (got.ok !== want.ok || got.read_value !== want.read_value ||
                        got.length !== want.length)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch: ok %0b/%0b read %02h/%02h len %0d/%0d",
                                     $realtime, want.ok, got.ok, want.read_value,
                                     got.read_value, want.length, got.length);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                fresh = apply_edit(iss_pkg::op_t'(req.op), int'(req.position), req.value);
                expected_outcomes = {expected_outcomes, fresh};
            end
            awaited    = expected_outcomes.size();
            fill_level = held;
        end
    end

endmodule

`default_nettype wire

/* sim/indexed_sequence_store_tb.sv */
`timescale 1ns / 100ps
`default_nettype none

module indexed_sequence_store_tb;

    localparam int CAP          = iss_pkg::CAPACITY_DEFAULT;
    localparam int PW           = iss_pkg::POS_W;
    localparam int DW           = iss_pkg::DATA_W;
    localparam int PHASE_ITEMS  = 375;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;

    int idle_pct;
    int stall_pct;
    int items_sent;
    int cycles;

    int fail_count;
    int awaited;
    int fill_level;
    int results_seen;
    int refusals;

    iss_req_if req_ch ();
    iss_rsp_if rsp_ch ();

    indexed_sequence_store dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sequence_store_checker watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .awaited      (awaited),
        .fill_level   (fill_level),
        .results_seen (results_seen),
        .refusals     (refusals)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // present one item, with random idle cycles ahead of it, and hold it until taken
    task automatic send_item(input iss_pkg::op_t code, input int where, input int val);
        bit taken;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= code;
        req_ch.position <= PW'(where);
        req_ch.value    <= DW'(val);
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = req_ch.ready;
            @(posedge clk);
        end
        items_sent++;
    endtask

    // stop sending until every awaited result has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited != 0);
        @(posedge clk);
    endtask

    // operation mix: 0 grows the row, 1 shrinks it, 2 is even
    function automatic iss_pkg::op_t pick_op(input int bias);
        int roll;
        roll = $urandom_range(0, 99);
        if (bias == 2)
            return iss_pkg::op_t'($urandom_range(0, 7));
        if (bias == 0)
        begin
            if (roll < 20) return iss_pkg::OP_PUSH_FRONT;
            if (roll < 40) return iss_pkg::OP_PUSH_BACK;
            if (roll < 60) return iss_pkg::OP_INSERT;
            if (roll < 65) return iss_pkg::OP_POP_FRONT;
            if (roll < 70) return iss_pkg::OP_POP_BACK;
            if (roll < 75) return iss_pkg::OP_ERASE;
            if (roll < 88) return iss_pkg::OP_READ;
            return iss_pkg::OP_WRITE;
        end
        if (roll < 5)  return iss_pkg::OP_PUSH_FRONT;
        if (roll < 10) return iss_pkg::OP_PUSH_BACK;
        if (roll < 20) return iss_pkg::OP_INSERT;
        if (roll < 37) return iss_pkg::OP_POP_FRONT;
        if (roll < 55) return iss_pkg::OP_POP_BACK;
        if (roll < 75) return iss_pkg::OP_ERASE;
        if (roll < 87) return iss_pkg::OP_READ;
        return iss_pkg::OP_WRITE;
    endfunction

    // stimulus
    initial
    begin
        int where;
        idle_pct   = 0;
        stall_pct  = 0;
        items_sent = 0;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= iss_pkg::OP_READ;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store refusals
        send_item(iss_pkg::OP_POP_FRONT, 0, 8'h3c);
        send_item(iss_pkg::OP_POP_BACK, 0, 8'h3c);
        send_item(iss_pkg::OP_READ, 0, 0);
        send_item(iss_pkg::OP_ERASE, 0, 0);
        send_item(iss_pkg::OP_WRITE, 0, 8'h55);
        send_item(iss_pkg::OP_INSERT, 1, 8'h66);
        // build a short row, insert at its end appends
        send_item(iss_pkg::OP_INSERT, 0, 8'ha5);
        send_item(iss_pkg::OP_PUSH_BACK, 31, 8'hff);
        send_item(iss_pkg::OP_PUSH_FRONT, 17, 8'h00);
        send_item(iss_pkg::OP_INSERT, 3, 8'h11);
        send_item(iss_pkg::OP_INSERT, 1, 8'h80);
        send_item(iss_pkg::OP_READ, 1, 8'hff);
        send_item(iss_pkg::OP_WRITE, 2, 8'h7f);
        send_item(iss_pkg::OP_READ, 2, 0);
        send_item(iss_pkg::OP_ERASE, 1, 8'hff);
        send_item(iss_pkg::OP_ERASE, 4, 0);
        send_item(iss_pkg::OP_READ, 31, 0);
        send_item(iss_pkg::OP_WRITE, 16, 8'h01);
        send_item(iss_pkg::OP_INSERT, 16, 8'h02);
        send_item(iss_pkg::OP_POP_FRONT, 31, 8'hff);
        send_item(iss_pkg::OP_POP_BACK, 0, 0);
        send_item(iss_pkg::OP_READ, 0, 0);
        drain();

        // random phases with different idling on each side
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 45;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 45;
                end
                default:
                begin
                    idle_pct  = 14;
                    stall_pct = 14;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mostly positions near the current length, sometimes anything
                if ($urandom_range(0, 99) < 80)
                    where = $urandom_range(0, fill_level + 1);
                else
                    where = $urandom_range(0, 31);
                send_item(pick_op((n / 40) % 3), where, $urandom_range(0, 255));
            end
            drain();
        end

        // closing wait for any stray result
        stall_pct = 0;
        repeat (4) @(posedge clk);

        $display("ran %0d items in %0d cycles; %0d results checked, %0d of them refusals",
                 items_sent, cycles, results_seen, refusals);
        $display("phases: no idling, sender idle, receiver stalling, both; capacity %0d", CAP);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
